@@ rtl/core/lfw_pkg.sv @@
// Shared types and constants of the Lax-Friedrichs wave step block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lfw_pkg;

    // Field widths
    localparam int SAMPLE_W   = 24;                  // signed Q8.16 sample
    localparam int FRAC_W     = 16;                  // fraction bits of Q8.16 and Q16.16
    localparam int RATIO_W    = 32;                  // unsigned Q16.16 courant ratio
    localparam int IDX_W      = 10;                  // reported grid index

    // Frame length limit and point counter (holds MAX_POINTS + 1 as overflow mark)
    localparam int MAX_POINTS = 1024;
    localparam int CNT_W      = $clog2(MAX_POINTS + 2);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    // Square root of max(u,0) * 2^16
    localparam int SQRT_IN_W  = SAMPLE_W + FRAC_W;   // radicand width
    localparam int ROOT_W     = SQRT_IN_W / 2;       // root width, one bit per step
    localparam int STEP_W     = $clog2(ROOT_W);

    // Flux and datapath widths
    localparam int FLUX_W     = SAMPLE_W - 1 + ROOT_W - FRAC_W;  // floor(U*S/2^16)
    localparam int DIFF_W     = FLUX_W + 1;                      // signed flux difference
    localparam int MUL_A_W    = RATIO_W + 1;                     // signed operand A
    localparam int PROD_W     = MUL_A_W + DIFF_W;                // signed product
    localparam int NUM_W      = PROD_W + 1;                      // numerator before rounding
    localparam int Q_W        = NUM_W - FRAC_W - 1;              // after shift by 2^17

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_end;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]           point_index;
        logic signed [SAMPLE_W-1:0] new_value;
        logic                       saturated;
        logic                       frame_done;
        logic                       overflow;
    } t_out;

endpackage

`default_nettype wire

@@ rtl/core/lfw_sqrt.sv @@
// Bit-iterative integer square root, one root bit per clock.
// Depends on lfw_pkg for the radicand and root widths.
`default_nettype none

module lfw_sqrt import lfw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SQRT_IN_W-1:0] i_radicand,
    output logic                 o_done,
    output logic [ROOT_W-1:0]    o_root
);

    localparam int REM_W = ROOT_W + 2;

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_step;
    logic [SQRT_IN_W-1:0] r_rad;
    logic [REM_W-1:0]     r_rem;
    logic [ROOT_W-1:0]    r_root;

    logic [REM_W+1:0]     w_rem_sh;
    logic [REM_W+1:0]     w_trial;
    logic [REM_W+1:0]     w_diff;
    logic                 w_fit;

    // Bring down the next two radicand bits and try 4*root+1
    always_comb begin
        w_rem_sh = {r_rem, r_rad[SQRT_IN_W-1 -: 2]};
        w_trial  = {2'b00, r_root, 2'b01};
        w_fit    = (w_rem_sh >= w_trial);
        w_diff   = w_rem_sh - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= w_fit ? w_diff[REM_W-1:0] : w_rem_sh[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

@@ rtl/core/lax_friedrichs_wave_step.sv @@
// Top level of the Lax-Friedrichs wave step block: sequencer, shared multiplier,
// frame bookkeeping and output register. Depends on lfw_pkg and lfw_sqrt.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready / i_in): one signed Q8.16 sample per
//    transaction, in grid order; frame_end marks the last point of a frame.
//  - Output channel (o_out_valid / i_out_ready / o_out): zero to three results
//    per input transaction. Interior result i-1 follows sample i; when a frame
//    closes, result N-1 and then result 0 (frame_done set) follow.
//  - Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes the Q16.16
//    courant ratio; always ready. Write it only while the block is idle.
//  - Sequence: each sample goes through the square root (one root bit per
//    cycle) and one multiply for its flux, then through one CMUL and one
//    FINAL step on the one shared multiplier for every result it produces.
//    The flux of each held sample is stored, so it is computed only once.
//  - o_in_ready is high only while the sequencer is idle; the last result may
//    still sit in the output register while the next sample is taken.
//  - Receiver stall: the sequencer holds in its final step until the output
//    register frees up; nothing is dropped.
//  - Reset (synchronous, active low): ratio returns to 1.0, stored samples,
//    fluxes and point count clear to zero, output register empties.
`default_nettype none

module lax_friedrichs_wave_step import lfw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // sample input
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in                i_in,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out               o_out,
    // courant ratio write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [RATIO_W-1:0] i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ROOT   = 6'b000010,
        S_FMUL   = 6'b000100,
        S_UPDATE = 6'b001000,
        S_CMUL   = 6'b010000,
        S_FINAL  = 6'b100000
    } t_state;

    // Pending result kinds, served lowest bit first
    localparam int PEND_INT  = 0;   // interior result i-1
    localparam int PEND_WRAP = 1;   // closing result N-1
    localparam int PEND_ZERO = 2;   // closing result 0

    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1) << FRAC_W;
    localparam logic signed [NUM_W-1:0] ROUND_ADD =
        {{(NUM_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};
    localparam logic signed [Q_W-1:0] Q_HI =
        {{(Q_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_LO =
        {{(Q_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

    t_state r_state, n_state;

    logic [2:0]                 r_pend;
    logic [CNT_W-1:0]           r_cnt;
    logic [RATIO_W-1:0]         r_ratio;

    // current transaction
    logic signed [SAMPLE_W-1:0] r_s;
    logic                       r_end;
    logic [FLUX_W-1:0]          r_fs;

    // frame store: samples and their fluxes
    logic signed [SAMPLE_W-1:0] r_first, r_second, r_older, r_newer;
    logic [FLUX_W-1:0]          r_first_f, r_second_f, r_older_f, r_newer_f;

    // operands captured for the interior result and the closing results
    logic signed [SAMPLE_W-1:0] r_hold_l;
    logic [FLUX_W-1:0]          r_hold_f;
    logic [IDX_W-1:0]           r_idx_int;
    logic [IDX_W-1:0]           r_idx_wrap;
    logic                       r_ovf;
    logic                       r_two;

    logic signed [PROD_W-1:0]   r_prod;

    logic                       r_out_valid;
    t_out                       r_out;

    // ------------------------------------------------------------------
    // Square root unit
    // ------------------------------------------------------------------
    logic                   w_in_acc;
    logic [SAMPLE_W-1:0]    w_u_in;
    logic                   w_root_done;
    logic [ROOT_W-1:0]      w_root;

    assign w_in_acc = i_in_valid && o_in_ready;
    // max(u,0) of the incoming sample
    assign w_u_in   = i_in.sample[SAMPLE_W-1] ? '0 : i_in.sample;

    lfw_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc),
        .i_radicand ({w_u_in, {FRAC_W{1'b0}}}),
        .o_done     (w_root_done),
        .o_root     (w_root)
    );

    // ------------------------------------------------------------------
    // Frame bookkeeping, evaluated in S_UPDATE
    // ------------------------------------------------------------------
    logic                   w_full;
    logic [CNT_W-1:0]       w_n;
    logic [CNT_W-1:0]       w_int_idx;
    logic [CNT_W-1:0]       w_wrap_idx;
    logic [2:0]             w_pend_new;
    logic [FLUX_W-1:0]      w_flux_s;

    always_comb begin
        w_full     = (r_cnt >= MAX_CNT);
        w_n        = w_full ? MAX_CNT : r_cnt + 1'b1;
        w_int_idx  = r_cnt - 1'b1;
        w_wrap_idx = w_n - 1'b1;
        w_flux_s   = r_prod[FRAC_W +: FLUX_W];
        w_pend_new = '0;
        w_pend_new[PEND_INT]  = !w_full && (r_cnt >= CNT_W'(2));
        w_pend_new[PEND_WRAP] = r_end && (w_n >= CNT_W'(2));
        w_pend_new[PEND_ZERO] = r_end;
    end

    // ------------------------------------------------------------------
    // Operand select for the result in progress
    // ------------------------------------------------------------------
    logic                       w_kind_int, w_kind_wrap;
    logic signed [SAMPLE_W-1:0] w_l, w_r;
    logic [FLUX_W-1:0]          w_fl, w_fr;
    logic [IDX_W-1:0]           w_idx;
    logic signed [DIFF_W-1:0]   w_diff;
    logic [2:0]                 w_pend_next;

    always_comb begin
        w_kind_int  = r_pend[PEND_INT];
        w_kind_wrap = !r_pend[PEND_INT] && r_pend[PEND_WRAP];
        if (w_kind_int) begin
            w_l = r_hold_l;  w_fl = r_hold_f;
            w_r = r_s;       w_fr = r_fs;
            w_idx = r_idx_int;
        end else if (w_kind_wrap) begin
            w_l = r_older;   w_fl = r_older_f;
            w_r = r_first;   w_fr = r_first_f;
            w_idx = r_idx_wrap;
        end else begin
            w_l = r_newer;   w_fl = r_newer_f;
            w_r = r_two ? r_second : r_first;
            w_fr = r_two ? r_second_f : r_first_f;
            w_idx = '0;
        end
        w_diff      = $signed({1'b0, w_fr}) - $signed({1'b0, w_fl});
        // drop the lowest pending kind
        w_pend_next = r_pend & (r_pend - 3'd1);
    end

    // ------------------------------------------------------------------
    // Shared multiplier: U*S for the flux, ratio*dF for the update
    // ------------------------------------------------------------------
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [DIFF_W-1:0]  w_mul_b;
    logic [SAMPLE_W-1:0]       w_u_s;

    assign w_u_s = r_s[SAMPLE_W-1] ? '0 : r_s;

    always_comb begin
        if (r_state == S_FMUL) begin
            w_mul_a = $signed(MUL_A_W'(w_root));
            w_mul_b = $signed(DIFF_W'(w_u_s));
        end else begin
            w_mul_a = $signed(MUL_A_W'(r_ratio));
            w_mul_b = w_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FMUL || r_state == S_CMUL) begin
            r_prod <= w_mul_a * w_mul_b;
        end
    end

    // ------------------------------------------------------------------
    // Final step: combine, round half up, saturate
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W:0] w_sum;
    logic signed [NUM_W-1:0]  w_num;
    logic signed [Q_W-1:0]    w_q;
    logic                     w_hi, w_lo;
    t_out                     w_res;
    logic                     w_load;

    always_comb begin
        w_sum = {w_l[SAMPLE_W-1], w_l} + {w_r[SAMPLE_W-1], w_r};
        w_num = (NUM_W'(w_sum) <<< FRAC_W) - NUM_W'(r_prod) + ROUND_ADD;
        w_q   = w_num[NUM_W-1:FRAC_W+1];
        w_hi  = (w_q > Q_HI);
        w_lo  = (w_q < Q_LO);
        w_res.point_index = w_idx;
        w_res.new_value   = w_hi ? Q_HI[SAMPLE_W-1:0] :
                            w_lo ? Q_LO[SAMPLE_W-1:0] : w_q[SAMPLE_W-1:0];
        w_res.saturated   = w_hi || w_lo;
        w_res.frame_done  = !w_kind_int && !w_kind_wrap;
        w_res.overflow    = !w_kind_int && r_ovf;
    end

    assign w_load = (r_state == S_FINAL) && (!r_out_valid || i_out_ready);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_in_acc) n_state = S_ROOT;
            S_ROOT:   if (w_root_done) n_state = S_FMUL;
            S_FMUL:   n_state = S_UPDATE;
            S_UPDATE: n_state = (w_pend_new != '0) ? S_CMUL : S_IDLE;
            S_CMUL:   n_state = S_FINAL;
            S_FINAL: begin
                if (w_load) n_state = (w_pend_next != '0) ? S_CMUL : S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= '0;
            r_cnt       <= '0;
            r_ratio     <= RATIO_RESET;
            r_out_valid <= 1'b0;
            r_first     <= '0;
            r_second    <= '0;
            r_older     <= '0;
            r_newer     <= '0;
            r_first_f   <= '0;
            r_second_f  <= '0;
            r_older_f   <= '0;
            r_newer_f   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_ratio <= i_cfg_data;

            if (r_state == S_UPDATE) begin
                r_pend <= w_pend_new;
                if (w_full) begin
                    // drop the sample and mark the frame overflowed
                    r_cnt <= r_end ? '0 : MAX_CNT + 1'b1;
                end else begin
                    r_cnt <= r_end ? '0 : w_n;
                    if (r_cnt == CNT_W'(0)) begin
                        r_first   <= r_s;
                        r_first_f <= w_flux_s;
                    end
                    if (r_cnt == CNT_W'(1)) begin
                        r_second   <= r_s;
                        r_second_f <= w_flux_s;
                    end
                    r_older   <= r_newer;
                    r_older_f <= r_newer_f;
                    r_newer   <= r_s;
                    r_newer_f <= w_flux_s;
                end
            end else if (w_load) begin
                r_pend <= w_pend_next;
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s   <= i_in.sample;
            r_end <= i_in.frame_end;
        end
        if (r_state == S_UPDATE) begin
            r_fs       <= w_flux_s;
            r_hold_l   <= r_older;
            r_hold_f   <= r_older_f;
            r_idx_int  <= w_int_idx[IDX_W-1:0];
            r_idx_wrap <= w_wrap_idx[IDX_W-1:0];
            r_ovf      <= w_full;
            r_two      <= (w_n >= CNT_W'(2));
        end
        if (w_load) r_out <= w_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_root_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_done |-> r_state == S_ROOT)
        else $error("square root finished outside its wait step");

    a_final_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMUL || r_state == S_FINAL) |-> r_pend != '0)
        else $error("result step entered with nothing pending");

    a_idle_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_pend == '0)
        else $error("input taken while results still pending");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT + 1'b1)
        else $error("point count beyond overflow mark");

    a_frame_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && r_end) |=> r_cnt == '0)
        else $error("point count not cleared at frame end");

endmodule

`default_nettype wire
